[sv/agtf_pkg.sv]
// Shared types and constants for the audio gain and tail fade block.
// Used by the controller, the datapath and the top level; depends on nothing.
package agtf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W = 16;
  localparam int Q_SHIFT = 15;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19660;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_WR,
    ST_PULL_RD,
    ST_FADE_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic gain_mul;
    logic push_wr;
    logic res_refuse;
    logic pull_clear;
    logic pull_raw;
    logic fade_mul;
    logic div_start;
    logic fade_done;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic pending;
    logic drain_done;
    logic fade;
    logic full;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

[sv/audio_gain_and_tail_fade.sv]
// Top level of the audio gain and tail fade block.
// Depends on agtf_pkg, agtf_ctrl, agtf_dp and agtf_div.
//
// Input items arrive on the in_ stream: in_tdata carries the sample, in_tlast
// marks the last sample of a chunk, and in_tuser selects a push (0) or a pull
// of the next held tail sample (1). Results leave on the out_ stream with the
// sample in out_tdata, out_tlast on the final sample of a drained tail and
// out_tuser set when a push was refused because a tail is still pending.
// The user must write the gain register through cfg_we and cfg_wdata only
// while idle; the block itself does not enforce this. One item is processed at
// a time. A push is decoded and written to the hold line, a refused push goes
// straight to the emit step, and a pull with no tail pending ends after decode.
// A pull of an unfaded tail sample reads the hold line; a pull of a faded tail
// sample also runs the fade multiply and the serial divider, which computes one
// quotient bit per cycle. Results go to the output register in the emit step.
// A finished result sits in the output register; the next item is accepted
// while it waits, but the block holds in its emit step if a second result is
// ready before the first is taken. Reset empties the hold line, clears the
// chunk count and any pending tail, and restores the default gain.
module audio_gain_and_tail_fade
  import agtf_pkg::*;
#(
  parameter int TAIL_LEN = 80,
  parameter int CHUNK_LEN = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [GAIN_W-1:0]   cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [15:0] sample_in
  input  logic                in_tlast,
  input  logic                in_tuser,   // [0] mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,  // [15:0] sample_out
  output logic                out_tlast,
  output logic                out_tuser   // [0] refused
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  agtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  agtf_dp #(
    .TAIL_LEN (TAIL_LEN),
    .CHUNK_LEN(CHUNK_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mode   (in_tuser),
    .in_sample (in_tdata),
    .in_last   (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  a_push_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !sts.pending)
    else $error("push written while a tail is pending");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten before it was taken");

  a_pull_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pull_raw || cmd.fade_done) |-> (sts.pending && !sts.drain_done))
    else $error("tail sample drained outside the held range");

endmodule

[sv/agtf_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for the tail fade; no package dependencies.
module agtf_div #(
  parameter int DW = 23,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic          busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign done = busy_r && (cnt_r == CNT_W'(DW));
  assign quotient = q_r;
  assign trial = {rem_r, q_r[DW-1]};
  assign fits = trial >= {1'b0, div_r};
  assign diff = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r && !done) begin
      q_r <= {q_r[DW-2:0], fits};
      rem_r <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

[sv/agtf_dp.sv]
// Datapath: gain multiply and saturation, circular hold line, fade multiply,
// divider and output register. Depends on agtf_pkg and agtf_div.
module agtf_dp
  import agtf_pkg::*;
#(
  parameter int TAIL_LEN = 80,
  parameter int CHUNK_LEN = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic                 cfg_we,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  input  logic                 in_mode,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic                 in_last,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SAMPLE_W-1:0]  out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);

  localparam int IW = (TAIL_LEN > 1) ? $clog2(TAIL_LEN) : 1;
  localparam int CW = $clog2(TAIL_LEN + 1);
  localparam int KW = $clog2(CHUNK_LEN + 1);
  localparam int PW = SAMPLE_W + CW;
  localparam int GP_W = SAMPLE_W + GAIN_W + 1;

  logic [SAMPLE_W-1:0] mem [TAIL_LEN];

  logic [GAIN_W-1:0]   gain_r;
  logic                mode_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                last_r;
  logic [IW-1:0]       head_r;
  logic [CW-1:0]       held_r;
  logic [CW-1:0]       drain_r;
  logic [KW-1:0]       chunk_r;
  logic                pending_r;
  logic                fade_r;
  logic signed [GP_W-1:0] gprod_r;
  logic [PW-1:0]       fprod_r;
  logic                fsign_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SAMPLE_W-1:0] res_r;
  logic                res_last_r;
  logic                res_ref_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_last_r;
  logic                out_ref_r;

  logic [CW:0]         rd_sum;
  logic [CW:0]         rd_wrap;
  logic [CW:0]         wr_sum;
  logic [CW:0]         wr_wrap;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       head_inc;
  logic                full;
  logic [KW-1:0]       chunk_inc;
  logic signed [GP_W-Q_SHIFT-1:0] g_sh;
  logic [SAMPLE_W-1:0] g_sat;
  logic [SAMPLE_W-1:0] mag;
  logic [CW-1:0]       fac;
  logic [CW-1:0]       drain_inc;
  logic                div_done;
  logic [PW-1:0]       div_q;
  logic [SAMPLE_W-1:0] q16;

  assign full = held_r == CW'(TAIL_LEN);

  always_comb begin
    rd_sum = (CW+1)'(head_r) + (CW+1)'((mode_r == MODE_PULL) ? drain_r : '0);
    rd_wrap = (rd_sum >= (CW+1)'(TAIL_LEN)) ? rd_sum - (CW+1)'(TAIL_LEN) : rd_sum;
    wr_sum = (CW+1)'(head_r) + (CW+1)'(held_r);
    wr_wrap = (wr_sum >= (CW+1)'(TAIL_LEN)) ? wr_sum - (CW+1)'(TAIL_LEN) : wr_sum;
    wr_addr = full ? head_r : wr_wrap[IW-1:0];
    head_inc = (head_r == IW'(TAIL_LEN - 1)) ? '0 : head_r + IW'(1);
    chunk_inc = (chunk_r < KW'(CHUNK_LEN)) ? chunk_r + KW'(1) : chunk_r;
    drain_inc = drain_r + CW'(1);
  end

  always_comb begin
    g_sh = gprod_r[GP_W-1:Q_SHIFT];
    if (g_sh > (GP_W-Q_SHIFT)'(SAMPLE_MAX)) begin
      g_sat = SAMPLE_MAX;
    end else if (g_sh < (GP_W-Q_SHIFT)'(SAMPLE_MIN)) begin
      g_sat = SAMPLE_MIN;
    end else begin
      g_sat = g_sh[SAMPLE_W-1:0];
    end
  end

  assign mag = rd_data_r[SAMPLE_W-1] ? (~rd_data_r + SAMPLE_W'(1)) : rd_data_r;
  assign fac = held_r - drain_r;
  assign q16 = div_q[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_wrap[IW-1:0]];
    if (cmd.push_wr) begin
      mem[wr_addr] <= g_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      sample_r <= in_sample;
      last_r <= in_last;
    end
    if (cmd.gain_mul) begin
      gprod_r <= $signed(sample_r) * $signed({1'b0, gain_r});
    end
    if (cmd.fade_mul) begin
      fprod_r <= PW'(mag) * PW'(fac);
      fsign_r <= rd_data_r[SAMPLE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      held_r <= '0;
      drain_r <= '0;
      chunk_r <= '0;
      pending_r <= 1'b0;
      fade_r <= 1'b0;
    end else if (cmd.push_wr) begin
      if (full) begin
        head_r <= head_inc;
      end else begin
        held_r <= held_r + CW'(1);
      end
      if (last_r) begin
        pending_r <= 1'b1;
        drain_r <= '0;
        fade_r <= chunk_inc < KW'(CHUNK_LEN);
        chunk_r <= '0;
      end else begin
        chunk_r <= chunk_inc;
      end
    end else if (cmd.pull_clear ||
                 ((cmd.pull_raw || cmd.fade_done) && drain_inc >= held_r)) begin
      pending_r <= 1'b0;
      held_r <= '0;
      drain_r <= '0;
    end else if (cmd.pull_raw || cmd.fade_done) begin
      drain_r <= drain_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_refuse) begin
      res_r <= '0;
      res_last_r <= 1'b0;
      res_ref_r <= 1'b1;
    end else if (cmd.push_wr) begin
      res_r <= rd_data_r;
      res_last_r <= 1'b0;
      res_ref_r <= 1'b0;
    end else if (cmd.pull_raw) begin
      res_r <= rd_data_r;
      res_last_r <= drain_inc >= held_r;
      res_ref_r <= 1'b0;
    end else if (cmd.fade_done) begin
      res_r <= fsign_r ? (~q16 + SAMPLE_W'(1)) : q16;
      res_last_r <= drain_inc >= held_r;
      res_ref_r <= 1'b0;
    end
  end

  agtf_div #(
    .DW(PW),
    .VW(CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(fprod_r),
    .divisor (held_r),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= res_r;
      out_last_r <= res_last_r;
      out_ref_r <= res_ref_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_ref_r;

  always_comb begin
    sts.mode = mode_r;
    sts.pending = pending_r;
    sts.drain_done = drain_r >= held_r;
    sts.fade = fade_r;
    sts.full = full;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

[sv/agtf_ctrl.sv]
// Controller state machine sequencing one item at a time through the datapath.
// Depends on agtf_pkg for the state type and the command and status structs.
module agtf_ctrl
  import agtf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.mode == MODE_PUSH) begin
          state_nxt = sts.pending ? ST_EMIT : ST_PUSH_WR;
        end else if (!sts.pending || sts.drain_done) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PULL_RD;
        end
      end
      ST_PUSH_WR: begin
        state_nxt = sts.full ? ST_EMIT : ST_IDLE;
      end
      ST_PULL_RD: begin
        state_nxt = sts.fade ? ST_FADE_MUL : ST_EMIT;
      end
      ST_FADE_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_DECODE: begin
        if (sts.mode == MODE_PUSH) begin
          cmd.res_refuse = sts.pending;
          cmd.gain_mul = !sts.pending;
        end else begin
          cmd.pull_clear = sts.pending && sts.drain_done;
        end
      end
      ST_PUSH_WR: begin
        cmd.push_wr = 1'b1;
      end
      ST_PULL_RD: begin
        cmd.fade_mul = sts.fade;
        cmd.pull_raw = !sts.fade;
      end
      ST_FADE_MUL: begin
        cmd.div_start = 1'b1;
      end
      ST_DIV: begin
        cmd.fade_done = sts.div_done;
      end
      ST_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[tb/audio_gain_and_tail_fade_test.sv]
// Self-checking testbench for audio_gain_and_tail_fade: a short directed table, then random
// chunks with tail drains, every result checked against table rows or a built-in predictor.
// Depends on agtf_pkg and the RTL of the block; reads no files.
module audio_gain_and_tail_fade_test;
  import agtf_pkg::*;

  localparam int TAIL_LEN = 80;
  localparam int CHUNK_LEN = 512;
  localparam int RAND_ITEMS = 1400;
  localparam int SETTLE = 60;
  localparam int CHOKE_CYCLES = 400;
  localparam int LIMIT = 1000000;
  localparam int N_ROWS = 25;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       refused;
  } out_rec_t;

  typedef struct packed {
    logic              gain_wr;
    logic [GAIN_W-1:0] gain_val;
    logic              mode;
    logic [15:0]       smp;
    logic              last;
    logic              known;
    logic              has_res;
    logic [15:0]       e_smp;
    logic              e_last;
    logic              e_ref;
  } vec_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [GAIN_W-1:0]   cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;  // [15:0] sample_in
  logic                in_tlast = 1'b0;
  logic                in_tuser = 1'b0;  // [0] mode
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;  // [15:0] sample_out
  logic                out_tlast;
  logic                out_tuser;  // [0] refused

  audio_gain_and_tail_fade #(
    .TAIL_LEN(TAIL_LEN),
    .CHUNK_LEN(CHUNK_LEN)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [SAMPLE_W-1:0] held_line [TAIL_LEN];
  logic [9:0]        chunk_n = '0;
  logic [6:0]        held_n = '0;
  logic [6:0]        drain_at = '0;
  logic              tail_armed = 1'b0;
  logic              fade_armed = 1'b0;
  logic [GAIN_W-1:0] gain_q = GAIN_RESET;

  out_rec_t due_samples[$];
  int       bad_n = 0;
  int       busy_n = 0;
  int       cyc_n = 0;
  bit       eager = 1'b0;
  bit       choke_req = 1'b0;

  vec_row_t vec_tab [N_ROWS] = '{
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h7FFF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h8000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h0000, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h1234, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h5A5A, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b1, 16'h8000, MODE_PUSH, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h8000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h7FFF, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h8000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h3FFF, 1'b1, 1'b0},
    '{1'b1, 16'hFFFF, MODE_PUSH, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h7FFF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h8000, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b1, 1'b1, 16'hC000, 1'b1, 1'b0},
    '{1'b1, 16'h0000, MODE_PUSH, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PUSH, 16'h7FFF, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, MODE_PULL, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0}
  };

  function automatic bit fade_predict(input logic mode, input logic [15:0] raw,
                                      input logic last, output out_rec_t res);
    longint prod;
    longint gained;
    int     v;
    int     f;
    int     k;
    bit     emit;
    res = '0;
    emit = 1'b0;
    if (mode == MODE_PUSH) begin
      if (tail_armed) begin
        res.refused = 1'b1;
        return 1'b1;
      end
      prod = longint'($signed(raw)) * longint'(gain_q);
      gained = prod >>> Q_SHIFT;
      if (gained > SAMPLE_MAX) gained = SAMPLE_MAX;
      if (gained < SAMPLE_MIN) gained = SAMPLE_MIN;
      if (held_n >= TAIL_LEN) begin
        res.smp = held_line[0];
        emit = 1'b1;
        for (k = 0; k < TAIL_LEN - 1; k++) held_line[k] = held_line[k + 1];
        held_line[TAIL_LEN - 1] = gained[15:0];
      end else begin
        held_line[held_n] = gained[15:0];
        held_n++;
      end
      if (chunk_n < CHUNK_LEN) chunk_n++;
      if (last) begin
        tail_armed = 1'b1;
        drain_at = '0;
        fade_armed = (chunk_n < CHUNK_LEN);
        chunk_n = '0;
      end
      return emit;
    end
    if (!tail_armed || drain_at >= held_n) begin
      if (tail_armed) begin
        tail_armed = 1'b0;
        held_n = '0;
        drain_at = '0;
      end
      return 1'b0;
    end
    v = held_line[drain_at];
    if (fade_armed) begin
      f = held_n;
      v = (v * (f - int'(drain_at))) / f;
    end
    res.smp = v[15:0];
    drain_at++;
    if (drain_at >= held_n) begin
      res.last = 1'b1;
      tail_armed = 1'b0;
      held_n = '0;
      drain_at = '0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    return eager ? 0 : $urandom_range(8, 0);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(15, 0))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 45) return $urandom_range(12, 1);
    if (r < 85) return $urandom_range(100, 70);
    return $urandom_range(79, 13);
  endfunction

  task automatic send_item(input logic mode, input logic [15:0] smp, input logic last,
                           input bit known = 1'b0, input bit has_res = 1'b0,
                           input out_rec_t preset = '0);
    int       gap;
    out_rec_t res;
    bit       emit;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= smp;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if (!(mode == MODE_PULL && !tail_armed)) busy_n++;
    emit = fade_predict(mode, smp, last, res);
    if (known) begin
      if (has_res) due_samples.push_back(preset);
    end else if (emit) begin
      due_samples.push_back(res);
    end
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] g);
    in_tvalid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wdata <= g;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_q = g;
  endtask

  task automatic run_chunk(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(9, 0) == 0) send_item(MODE_PULL, 16'($urandom), 1'($urandom));
      send_item(MODE_PUSH, pick_sample(), k == len - 1);
    end
    while (tail_armed) begin
      if ($urandom_range(7, 0) == 0) send_item(MODE_PUSH, pick_sample(), 1'($urandom));
      else send_item(MODE_PULL, 16'($urandom), 1'($urandom));
    end
    if ($urandom_range(3, 0) == 0) send_item(MODE_PULL, 16'($urandom), 1'($urandom));
  endtask

  always @(posedge clk) begin
    cyc_n <= cyc_n + 1;
    if (cyc_n == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        out_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    out_rec_t want;
    out_rec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.smp = $signed(out_tdata);
      got.last = out_tlast;
      got.refused = out_tuser;
      if (due_samples.size() == 0) begin
        bad_n++;
        if (bad_n <= 10)
          $display("unexpected result: sample=%0d tlast=%0b tuser=%0b",
                   got.smp, got.last, got.refused);
      end else begin
        want = due_samples.pop_front();
        if (got.smp !== want.smp || got.last !== want.last || got.refused !== want.refused) begin
          bad_n++;
          if (bad_n <= 10)
            $display("result mismatch: expected sample=%0d tlast=%0b tuser=%0b, got sample=%0d tlast=%0b tuser=%0b",
                     want.smp, want.last, want.refused, got.smp, got.last, got.refused);
        end
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          ph;
    out_rec_t    preset;
    logic [15:0] g;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (r = 0; r < N_ROWS; r++) begin
      if (vec_tab[r].gain_wr) begin
        set_gain(vec_tab[r].gain_val);
      end else begin
        preset.smp = vec_tab[r].e_smp;
        preset.last = vec_tab[r].e_last;
        preset.refused = vec_tab[r].e_ref;
        send_item(vec_tab[r].mode, vec_tab[r].smp, vec_tab[r].last,
                  vec_tab[r].known, vec_tab[r].has_res, preset);
      end
    end
    busy_n = 0;
    for (ph = 0; ph < 5 || busy_n < RAND_ITEMS; ph++) begin
      case (ph)
        0: g = 16'($urandom_range(32767, 1));
        1: g = 16'h8000;
        2: g = 16'h0000;
        3: g = 16'hFFFF;
        4: g = 16'($urandom_range(65535, 32769));
        default: g = 16'($urandom_range(32768, 0));
      endcase
      set_gain(g);
      eager = (ph % 3 == 2);
      if (ph == 1) choke_req = 1'b1;
      if (ph == 0) run_chunk(CHUNK_LEN - 1);
      else if (ph == 1) run_chunk(CHUNK_LEN + 1);
      else run_chunk(pick_len());
    end
    eager = 1'b0;
    in_tvalid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (bad_n == 0 && due_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[audio_gain_and_tail_fade.f]
sv/agtf_pkg.sv
sv/agtf_div.sv
sv/agtf_dp.sv
sv/agtf_ctrl.sv
sv/audio_gain_and_tail_fade.sv
tb/audio_gain_and_tail_fade_test.sv
